// File: rtl/core/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros used by the port-level checker of the formatter.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every rising clock edge outside reset.
`define CHK_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Condition that must never be true outside reset.
`define CHK_NEVER(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) else $error(msg);

`endif

// File: rtl/core/itaf_pkg.sv
// ---------------------------------------------------------------------------
// itaf_pkg
// Types, constants and helpers shared by the integer-to-ASCII formatter.
// ---------------------------------------------------------------------------
package itaf_pkg;

    localparam int VALUE_W    = 32;
    localparam int TUSER_W    = 4;
    localparam int CHAR_W     = 8;
    localparam int BCD_DIGITS = 10;
    localparam int BCD_W      = 4 * BCD_DIGITS;
    localparam int BITCNT_W   = 6;
    localparam int REM_W      = 4;

    localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_A    = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_X    = 8'h78;
    localparam logic [3:0]        NIB_MASK  = 4'hF;
    localparam logic [3:0]        DEC_BASE  = 4'd10;

    // Operand width codes; any other code is treated as 32 bits.
    localparam logic [1:0] WCODE_8  = 2'd0;
    localparam logic [1:0] WCODE_16 = 2'd1;

    typedef struct packed {
        logic load;
        logic shift;
        logic count;
        logic step;
    } itaf_cmd_t;

    typedef struct packed {
        logic use_hex;
        logic conv_last;
        logic char_last;
    } itaf_status_t;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] nib);
        logic [3:0] n;
        n = nib & NIB_MASK;
        if (n < DEC_BASE) begin
            return CHAR_ZERO + {4'd0, n};
        end
        return CHAR_A + {4'd0, n - DEC_BASE};
    endfunction

endpackage

// File: rtl/core/itaf_ctrl.sv
// ---------------------------------------------------------------------------
// itaf_ctrl
// Sequencer: accept a word; for decimal, run the binary-to-BCD pass and size
// the text; then hand out one character per output handshake.
// ---------------------------------------------------------------------------
module itaf_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    input  itaf_pkg::itaf_status_t status,
    output itaf_pkg::itaf_cmd_t    cmd
);
    import itaf_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_CONV  = 4'b0010,
        ST_COUNT = 4'b0100,
        ST_EMIT  = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_CONV;
                end
            end
            ST_CONV: begin
                // Hex needs no conversion; its digits come straight from the operand.
                if (status.use_hex) begin
                    state_next = ST_EMIT;
                end else begin
                    cmd.shift = 1'b1;
                    if (status.conv_last) begin
                        state_next = ST_COUNT;
                    end
                end
            end
            ST_COUNT: begin
                cmd.count  = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (m_tready) begin
                    cmd.step = 1'b1;
                    if (status.char_last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_EMIT);

endmodule

// File: rtl/core/itaf_datapath.sv
// ---------------------------------------------------------------------------
// itaf_datapath
// Operand register, shift-and-add-3 BCD converter, digit count and the
// character selection for the current output position.
// ---------------------------------------------------------------------------
module itaf_datapath (
    input  logic                                aclk,
    input  itaf_pkg::itaf_cmd_t                 cmd,
    input  logic [itaf_pkg::VALUE_W-1:0]        s_tdata,
    input  logic [itaf_pkg::TUSER_W-1:0]        s_tuser,
    output logic [itaf_pkg::CHAR_W-1:0]         out_char,
    output logic                                out_last,
    output itaf_pkg::itaf_status_t              status
);
    import itaf_pkg::*;

    logic [VALUE_W-1:0]  val_reg;
    logic [BCD_W-1:0]    bcd_reg;
    logic [BITCNT_W-1:0] bitcnt_reg;
    logic [REM_W-1:0]    ndig_reg;
    logic [REM_W-1:0]    rem_reg;
    logic                hex_reg;

    logic                in_hex;
    logic [1:0]          in_wcode;
    logic                in_prefix;
    logic [VALUE_W-1:0]  masked_val;
    logic [VALUE_W-1:0]  aligned_val;
    logic [BITCNT_W-1:0] width_bits;
    logic [REM_W-1:0]    hex_digits;
    logic [BCD_W-1:0]    bcd_adj;
    logic [3:0]          bcd_dig [BCD_DIGITS];
    logic [REM_W-1:0]    lead_cnt;
    logic [REM_W-1:0]    idx;
    logic [3:0]          cur_nib;

    assign in_hex    = s_tuser[0];
    assign in_wcode  = s_tuser[2:1];
    assign in_prefix = s_tuser[3];

    always_comb begin
        case (in_wcode)
            WCODE_8: begin
                masked_val  = {24'd0, s_tdata[7:0]};
                aligned_val = {s_tdata[7:0], 24'd0};
                width_bits  = 6'd8;
                hex_digits  = 4'd2;
            end
            WCODE_16: begin
                masked_val  = {16'd0, s_tdata[15:0]};
                aligned_val = {s_tdata[15:0], 16'd0};
                width_bits  = 6'd16;
                hex_digits  = 4'd4;
            end
            default: begin
                masked_val  = s_tdata;
                aligned_val = s_tdata;
                width_bits  = 6'd32;
                hex_digits  = 4'd8;
            end
        endcase
    end

    // Every BCD digit of five or more gets three added before the shift.
    always_comb begin
        for (int i = 0; i < BCD_DIGITS; i++) begin
            bcd_dig[i] = bcd_reg[4*i +: 4];
            if (bcd_reg[4*i +: 4] >= 4'd5) begin
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4] + 4'd3;
            end else begin
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4];
            end
        end
    end

    // Number of significant decimal digits; zero still prints one digit.
    always_comb begin
        lead_cnt = 4'd1;
        for (int i = 0; i < BCD_DIGITS; i++) begin
            if (bcd_reg[4*i +: 4] != 4'd0) begin
                lead_cnt = REM_W'(i + 1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            hex_reg    <= in_hex;
            bcd_reg    <= '0;
            bitcnt_reg <= width_bits;
            if (in_hex) begin
                val_reg  <= masked_val;
                ndig_reg <= hex_digits;
                rem_reg  <= in_prefix ? hex_digits + 4'd2 : hex_digits;
            end else begin
                val_reg <= aligned_val;
            end
        end
        if (cmd.shift) begin
            bcd_reg    <= {bcd_adj[BCD_W-2:0], val_reg[VALUE_W-1]};
            val_reg    <= {val_reg[VALUE_W-2:0], 1'b0};
            bitcnt_reg <= bitcnt_reg - 6'd1;
        end
        if (cmd.count) begin
            ndig_reg <= lead_cnt;
            rem_reg  <= lead_cnt;
        end
        if (cmd.step) begin
            rem_reg <= rem_reg - 4'd1;
        end
    end

    assign idx     = rem_reg - 4'd1;
    assign cur_nib = hex_reg ? val_reg[4*idx[2:0] +: 4] : bcd_dig[idx];

    always_comb begin
        if (hex_reg && (rem_reg > ndig_reg)) begin
            out_char = (rem_reg == ndig_reg + 4'd2) ? CHAR_ZERO : CHAR_X;
        end else begin
            out_char = digit_char(cur_nib);
        end
    end

    assign out_last         = (rem_reg == 4'd1);
    assign status.use_hex   = hex_reg;
    assign status.conv_last = (bitcnt_reg == 6'd1);
    assign status.char_last = out_last;

endmodule

// File: rtl/core/integer_to_ascii_formatter_unit.sv
// ---------------------------------------------------------------------------
// integer_to_ascii_formatter_unit
// Formats an unsigned 8/16/32-bit number as decimal or uppercase hex ASCII,
// one character per output word, with tlast on the final character.
// ---------------------------------------------------------------------------
//  Channel  Dir  Word contents
//  s_       in   tdata: value[31:0]; tuser: use_hex, width_code[1:0], with_prefix
//  m_       out  tdata: ascii_char[7:0]; tlast: is_last
//
// Hex: the accept state, a setup state, then one character per cycle while m_tready is high.
// Decimal: accept, then one shift-add-3 step per operand bit (8, 16 or 32),
// a digit-count state, then one character per cycle while m_tready is high.
// One number is in flight at a time; s_tready is high only when idle.
// A stalled output holds its character. Synchronous active-low reset.
// ---------------------------------------------------------------------------
module integer_to_ascii_formatter_unit (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [itaf_pkg::VALUE_W-1:0] s_tdata,  // [31:0] value
    input  logic [itaf_pkg::TUSER_W-1:0] s_tuser,  // [0] use_hex, [2:1] width_code,
                                                   // [3] with_prefix
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [itaf_pkg::CHAR_W-1:0]  m_tdata,  // [7:0] ascii_char
    output logic                         m_tlast
);
    import itaf_pkg::*;

    itaf_cmd_t    cmd;
    itaf_status_t status;

    itaf_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    itaf_datapath u_datapath (
        .aclk     (aclk),
        .cmd      (cmd),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .out_char (m_tdata),
        .out_last (m_tlast),
        .status   (status)
    );

endmodule

// File: rtl/core/itaf_checker.sv
// ---------------------------------------------------------------------------
// itaf_checker
// Port-level checks of the formatter, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module itaf_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_tvalid,
    input logic                         s_tready,
    input logic                         m_tvalid,
    input logic                         m_tready,
    input logic [itaf_pkg::CHAR_W-1:0]  m_tdata,
    input logic                         m_tlast
);
    import itaf_pkg::*;

    logic in_acc;
    logic out_acc;
    logic char_ok;

    assign in_acc  = s_tvalid && s_tready;
    assign out_acc = m_tvalid && m_tready;
    assign char_ok = ((m_tdata >= CHAR_ZERO) && (m_tdata <= 8'h39)) ||
                     ((m_tdata >= CHAR_A) && (m_tdata <= 8'h46)) ||
                     (m_tdata == CHAR_X);

    `CHK_ASSERT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast), "output word changed while stalled")
    `CHK_NEVER(a_one_in_flight, aclk, aresetn, s_tready && m_tvalid, "input taken while text is pending")
    `CHK_ASSERT(a_busy_after_accept, aclk, aresetn, in_acc |=> !s_tready, "ready stayed high after an accept")
    `CHK_ASSERT(a_char_set, aclk, aresetn, m_tvalid |-> char_ok, "character outside digit set")
    `CHK_ASSERT(a_last_ends, aclk, aresetn, out_acc && m_tlast |=> !m_tvalid, "output continued after last")

endmodule

bind integer_to_ascii_formatter_unit itaf_checker u_itaf_checker (.*);

// File: sim/itaf_text_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// itaf_text_checker
// Watches both streams of the integer-to-ASCII formatter, works out the text
// each accepted number should produce and compares every output word with it.
// ----------------------------------------------------------------------------
module itaf_text_checker (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    input  logic                         s_tready,
    input  logic [itaf_pkg::VALUE_W-1:0] s_tdata,  // [31:0] value
    input  logic [itaf_pkg::TUSER_W-1:0] s_tuser,  // [0] use_hex, [2:1] width_code,
                                                   // [3] with_prefix
    input  logic                         m_tvalid,
    input  logic                         m_tready,
    input  logic [itaf_pkg::CHAR_W-1:0]  m_tdata,  // [7:0] ascii_char
    input  logic                         m_tlast,
    output int                           fail_count,
    output int                           pending,
    output int                           chars_seen
);
    import itaf_pkg::*;

    localparam int MAX_REPORTS = 40;

    typedef struct packed {
        logic       with_prefix;
        logic [1:0] width_code;
        logic       use_hex;
    } fmt_sel_t;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last;
    } char_word_t;

    char_word_t text_q[$];
    int         errs   = 0;
    int         nchars = 0;

    function automatic void push_char(input logic [CHAR_W-1:0] ch, input logic last);
        char_word_t w;
        w.ch   = ch;
        w.last = last;
        text_q.push_back(w);
    endfunction

    function automatic void predict_text(input logic [VALUE_W-1:0] raw, input fmt_sel_t sel);
        logic [VALUE_W-1:0] v;
        logic [VALUE_W-1:0] rem;
        logic [CHAR_W-1:0]  dec_rev [0:BCD_DIGITS-1];
        logic [3:0]         nib;
        int                 ndig;
        int                 k;
        case (sel.width_code)
            WCODE_8:  v = raw & 32'h0000_00FF;
            WCODE_16: v = raw & 32'h0000_FFFF;
            default:  v = raw;
        endcase
        if (sel.use_hex) begin
            ndig = (sel.width_code == WCODE_8) ? 2 : (sel.width_code == WCODE_16) ? 4 : 8;
            if (sel.with_prefix) begin
                push_char(CHAR_ZERO, 1'b0);
                push_char(CHAR_X, 1'b0);
            end
            for (k = ndig - 1; k >= 0; k--) begin
                nib = v[k*4 +: 4];
                if (nib < DEC_BASE) begin
                    push_char(CHAR_ZERO + {4'd0, nib}, k == 0);
                end else begin
                    push_char(CHAR_A + {4'd0, nib - DEC_BASE}, k == 0);
                end
            end
        end else begin
            // Digits come out least significant first, so they are reversed on the way out.
            ndig = 0;
            do begin
                rem           = v % 32'd10;
                dec_rev[ndig] = CHAR_ZERO + rem[CHAR_W-1:0];
                v             = v / 32'd10;
                ndig++;
            end while (v != 0);
            for (k = ndig - 1; k >= 0; k--) begin
                push_char(dec_rev[k], k == 0);
            end
        end
    endfunction

    always @(posedge aclk) begin
        char_word_t want;
        int         errs_before;
        errs_before = errs;
        if (!aresetn) begin
            text_q.delete();
        end else begin
            if (s_tvalid && s_tready) begin
                predict_text(s_tdata, s_tuser);
            end
            if (m_tvalid && m_tready) begin
                nchars++;
                if (text_q.size() == 0) begin
                    errs++;
                    if (errs <= MAX_REPORTS) begin
                        $display("%0t: unexpected word: expected none, actual char 0x%02h last %0b",
                                 $time, m_tdata, m_tlast);
                    end
                end else begin
                    want = text_q.pop_front();
                    if (m_tdata !== want.ch || m_tlast !== want.last) begin
                        errs++;
                        if (errs <= MAX_REPORTS) begin
                            $write("%0t: word mismatch: expected char 0x%02h last %0b, ",
                                   $time, want.ch, want.last);
                            $display("actual char 0x%02h last %0b", m_tdata, m_tlast);
                        end
                    end
                end
                if (errs_before <= MAX_REPORTS && errs > MAX_REPORTS) begin
                    $display("%0t: further mismatches are counted but not listed", $time);
                end
            end
        end
        fail_count <= errs;
        pending    <= text_q.size();
        chars_seen <= nchars;
    end

endmodule

// File: sim/tb_integer_to_ascii_formatter_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_integer_to_ascii_formatter_unit
// Feeds numbers of every width and radix to the formatter in random bursts,
// stalls its output on a pattern of its own and reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb_integer_to_ascii_formatter_unit;
    import itaf_pkg::*;

    localparam int         RANDOM_NUMBERS = 330;
    localparam int         LIMIT_CYCLES   = 400000;
    localparam int         DRAIN_CYCLES   = 120;
    localparam logic [1:0] WCODE_32       = 2'd2;
    localparam logic [1:0] WCODE_WIDE     = 2'd3;  // unused code, formats as 32 bits

    typedef enum logic [1:0] {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_mode_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [VALUE_W-1:0]   s_tdata  = '0;
    logic [TUSER_W-1:0]   s_tuser  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [CHAR_W-1:0]    m_tdata;
    logic                 m_tlast;

    int       check_errors;
    int       words_pending;
    int       chars_seen;
    int       cycles     = 0;
    int       burst_left = 0;
    int       n_hex      = 0;
    int       n_dec      = 0;
    rx_mode_t rx_mode    = RX_OPEN;
    int       rx_left    = 0;

    always #4 aclk = ~aclk;

    integer_to_ascii_formatter_unit u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    itaf_text_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .fail_count (check_errors),
        .pending    (words_pending),
        .chars_seen (chars_seen)
    );

    // The receiver switches between open, lightly and heavily stalled and a
    // fixed duty pattern, each held for a random stretch of cycles.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_left  <= 0;
        end else begin
            if (rx_left == 0) begin
                rx_mode <= rx_mode_t'($urandom_range(0, 3));
                rx_left <= $urandom_range(20, 200);
            end else begin
                rx_left <= rx_left - 1;
            end
            case (rx_mode)
                RX_OPEN:  m_tready <= 1'b1;
                RX_LIGHT: m_tready <= ($urandom_range(0, 3) != 0);
                RX_HEAVY: m_tready <= ($urandom_range(0, 3) == 0);
                default:  m_tready <= (cycles % 7 > 2);
            endcase
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == LIMIT_CYCLES) begin
            $display("%0t: run stopped after %0d cycles with %0d words still expected",
                     $time, cycles, words_pending);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic send_number(input logic [VALUE_W-1:0] value, input logic hex,
                               input logic [1:0] wcode, input logic prefix);
        int          gap;
        logic [31:0] junk;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24);
            if (gap != 0) begin
                junk = $urandom;
                s_tvalid <= 1'b0;
                s_tdata  <= junk;
                s_tuser  <= junk[7:4];
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 12);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        s_tuser  <= {prefix, wcode, hex};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        burst_left--;
        if (hex) n_hex++;
        else n_dec++;
    endtask

    // Mix of full-range values, small numbers, neighbors of powers of ten and
    // values shifted right by 0 to 31 bits.
    function automatic logic [VALUE_W-1:0] random_operand();
        logic [VALUE_W-1:0] p;
        logic [VALUE_W-1:0] r;
        int                 k;
        r = $urandom;
        case ($urandom_range(0, 3))
            0: random_operand = r;
            1: random_operand = $urandom_range(0, 120);
            2: begin
                p = 32'd1;
                for (k = $urandom_range(0, 9); k > 0; k--) p = p * 32'd10;
                random_operand = p + $urandom_range(0, 2) - 32'd1;
            end
            default: random_operand = r >> $urandom_range(0, 31);
        endcase
    endfunction

    initial begin
        int i;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Decimal edges: zero and full scale at each width, truncation of the
        // upper bits, the unused width code, ten digits and digit boundaries.
        send_number(32'd0,          1'b0, WCODE_8,    1'b0);
        send_number(32'd0,          1'b0, WCODE_16,   1'b1);
        send_number(32'd0,          1'b0, WCODE_32,   1'b0);
        send_number(32'd255,        1'b0, WCODE_8,    1'b0);
        send_number(32'd65535,      1'b0, WCODE_16,   1'b0);
        send_number(32'hFFFF_FFFF,  1'b0, WCODE_32,   1'b0);
        send_number(32'hFFFF_FFFF,  1'b0, WCODE_8,    1'b0);
        send_number(32'hFFFF_FFFF,  1'b0, WCODE_WIDE, 1'b1);
        send_number(32'd1000000000, 1'b0, WCODE_32,   1'b0);
        send_number(32'd10,         1'b0, WCODE_8,    1'b0);
        send_number(32'd9,          1'b0, WCODE_8,    1'b0);
        send_number(32'h0001_0064,  1'b0, WCODE_16,   1'b1);
        // Hex edges: zero with and without prefix, every digit letter, widths.
        send_number(32'd0,          1'b1, WCODE_8,    1'b0);
        send_number(32'd0,          1'b1, WCODE_32,   1'b1);
        send_number(32'hFFFF_FFFF,  1'b1, WCODE_8,    1'b1);
        send_number(32'hFFFF_FFFF,  1'b1, WCODE_16,   1'b0);
        send_number(32'h1234_5678,  1'b1, WCODE_32,   1'b1);
        send_number(32'h9ABC_DEF0,  1'b1, WCODE_32,   1'b0);
        send_number(32'hDEAD_BEEF,  1'b1, WCODE_WIDE, 1'b1);
        send_number(32'h0000_00A5,  1'b1, WCODE_16,   1'b1);
        send_number(32'h5A5A_5A5A,  1'b1, WCODE_8,    1'b0);

        for (i = 0; i < RANDOM_NUMBERS; i++) begin
            send_number(random_operand(), $urandom_range(0, 1) == 1,
                        2'($urandom_range(0, 3)), $urandom_range(0, 1) == 1);
        end
        s_tvalid <= 1'b0;

        // Waiting for the clock lets the checker publish the text of the last number.
        @(posedge aclk);
        while (words_pending != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Formatted %0d numbers (%0d decimal, %0d hex) at all widths,",
                 n_dec + n_hex, n_dec, n_hex);
        $display("checked %0d output characters under bursty input and stalled output.",
                 chars_seen);
        if (check_errors == 0 && words_pending == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// File: files.f
+incdir+rtl/core
rtl/core/itaf_pkg.sv
rtl/core/itaf_ctrl.sv
rtl/core/itaf_datapath.sv
rtl/core/integer_to_ascii_formatter_unit.sv
rtl/core/itaf_checker.sv
sim/itaf_text_checker.sv
sim/tb_integer_to_ascii_formatter_unit.sv
